>>> hw/rtl/gmma_pkg.sv
// Shared types and constants for the grouped min/max accumulator.
package gmma_pkg;

	localparam logic [63:0] POS_INF_BITS = 64'h7FF0000000000000;
	localparam logic [63:0] NEG_INF_BITS = 64'hFFF0000000000000;
	localparam logic [63:0] NA_REAL_BITS = 64'h7FF00000000007A2;

	typedef enum logic [1:0] {
		ST_EMPTY = 2'd0,
		ST_VALUE = 2'd1,
		ST_NA    = 2'd2
	} slot_st_t;

	typedef enum logic [1:0] {
		REG_MODE_MAX    = 2'd0,
		REG_AXIS_MODE   = 2'd1,
		REG_GROUP_COUNT = 2'd2,
		REG_ROW_COUNT   = 2'd3
	} reg_idx_t;

	// item sequencer: idle, memory read issued, data back for modify/write
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_READ   = 2'd1,
		PH_MODIFY = 2'd2
	} phase_t;

	localparam logic KIND_ACC  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic        mode_max;
		logic        axis_mode;
		logic [12:0] group_count;
		logic [12:0] row_count;
	} cfg_t;

	// strict a < b on IEEE doubles, false when either is NaN
	function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
		logic a_nan, b_nan, a_zero, b_zero;
		a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
		b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
		a_zero = (a[62:0] == 63'd0);
		b_zero = (b[62:0] == 63'd0);
		if (a_nan || b_nan)
			return 1'b0;
		if (a_zero && b_zero)
			return 1'b0;
		if (a[63] != b[63])
			return a[63];
		if (a[63])
			return a[62:0] > b[62:0];
		return a[62:0] < b[62:0];
	endfunction

endpackage

>>> hw/rtl/gmma_if.sv
// Valid/ready stream interfaces for the accumulator.
interface gmma_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [11:0] group;
	logic [11:0] row;
	logic [63:0] value;
	logic        value_is_na;
	modport source (output valid, kind, group, row, value, value_is_na, input ready);
	modport sink (input valid, kind, group, row, value, value_is_na, output ready);
endinterface

interface gmma_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_value;
	logic        result_is_na;
	logic        slot_error;
	modport source (output valid, result_value, result_is_na, slot_error, input ready);
	modport sink (input valid, result_value, result_is_na, slot_error, output ready);
endinterface

interface gmma_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/grouped_min_max_accumulator_top.sv
// Top level of the grouped min/max accumulator.
//  channel | dir | handshake   | payload
//  in      | in  | valid/ready | kind, group, row, value, value_is_na
//  out     | out | valid/ready | result_value, result_is_na, slot_error
//  cfg     | in  | valid/ready | index, data
// An accumulate passes through three steps: accept with address stage, memory
// read, modify/write. A read holds the input until its result leaves the output
// register; an out-of-table item returns its result after the address stage.
// The status and value memories have a registered read; the next item is taken
// only after the write-back, so no forwarding path is needed.
// After reset a clearing pass writes every slot of the status memory empty.
// A result waits in the output register; the next item is not taken until it
// leaves.
module grouped_min_max_accumulator_top import gmma_pkg::*; #(
	parameter int SLOT_DEPTH = 4096
) (
	input logic clk,
	input logic arst_n,
	gmma_in_if.sink    in_ch,
	gmma_out_if.source out_ch,
	gmma_cfg_if.sink   cfg_ch
);
	localparam int SW = $clog2(SLOT_DEPTH);

	cfg_t cfg_q;
	logic [SW:0] clr_q;
	logic clearing;
	phase_t phase_q, phase_d;
	logic kind_q, na_q;
	logic [63:0] value_q;
	logic [SW-1:0] slot_s1;
	logic bad_s1;
	logic [63:0] ext_rd;
	logic [1:0]  st_rd;
	logic st_we, ex_we;
	logic [SW-1:0] st_waddr;
	logic [1:0] st_wdata;
	logic [63:0] cur, sentinel;
	logic take, better;
	logic ovalid_q;
	logic [63:0] oval_q;
	logic ona_q, oerr_q;

	assign clearing = !clr_q[SW];
	assign in_ch.ready = !clearing && phase_q == PH_IDLE && !ovalid_q;
	assign cfg_ch.ready = 1'b1;
	assign take = in_ch.valid && in_ch.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mode_max: 1'b0, axis_mode: 1'b0, group_count: 13'd1, row_count: 13'd1};
		end else if (cfg_ch.valid) begin
			unique case (reg_idx_t'(cfg_ch.index))
				REG_MODE_MAX:    cfg_q.mode_max    <= cfg_ch.data[0];
				REG_AXIS_MODE:   cfg_q.axis_mode   <= cfg_ch.data[0];
				REG_GROUP_COUNT: cfg_q.group_count <= cfg_ch.data;
				REG_ROW_COUNT:   cfg_q.row_count   <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	gmma_addr #(.SLOT_DEPTH(SLOT_DEPTH)) u_addr (
		.clk(clk), .en(take), .cfg(cfg_q), .group(in_ch.group), .row(in_ch.row),
		.slot_s1(slot_s1), .bad_s1(bad_s1)
	);

	// sequencer next state
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE:   if (take) phase_d = PH_READ;
			PH_READ:   phase_d = bad_s1 ? PH_IDLE : PH_MODIFY;
			PH_MODIFY: phase_d = PH_IDLE;
			default:   phase_d = PH_IDLE;
		endcase
	end

	// sequencer state and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			clr_q   <= '0;
		end else begin
			if (clearing)
				clr_q <= clr_q + 1'b1;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q  <= in_ch.kind;
			na_q    <= in_ch.value_is_na;
			value_q <= in_ch.value;
		end
	end

	// modify, or clear a status slot while clearing
	always_comb begin
		sentinel = cfg_q.mode_max ? NEG_INF_BITS : POS_INF_BITS;
		cur = (st_rd == ST_VALUE) ? ext_rd : sentinel;
		better = cfg_q.mode_max ? fp_lt(cur, value_q) : fp_lt(value_q, cur);
		st_we = 1'b0;
		ex_we = 1'b0;
		st_wdata = ST_EMPTY;
		st_waddr = slot_s1;
		if (clearing) begin
			st_we = 1'b1;
			st_waddr = clr_q[SW-1:0];
		end else if (phase_q == PH_MODIFY) begin
			if (kind_q == KIND_READ) begin
				st_we = 1'b1;
			end else if (st_rd != ST_NA) begin
				if (na_q) begin
					st_we = 1'b1;
					st_wdata = ST_NA;
				end else if (better) begin
					st_we = 1'b1;
					ex_we = 1'b1;
					st_wdata = ST_VALUE;
				end
			end
		end
	end

	gmma_ram #(.WIDTH(2), .DEPTH(SLOT_DEPTH)) u_status (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(slot_s1), .rdata(st_rd)
	);

	gmma_ram #(.WIDTH(64), .DEPTH(SLOT_DEPTH)) u_extreme (
		.clk(clk), .we(ex_we), .waddr(slot_s1), .wdata(value_q),
		.raddr(slot_s1), .rdata(ext_rd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (phase_q == PH_READ && bad_s1) begin
			ovalid_q <= 1'b1;
		end else if (phase_q == PH_MODIFY && kind_q == KIND_READ) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_READ && bad_s1) begin
			oval_q <= '0;
			ona_q  <= 1'b0;
			oerr_q <= 1'b1;
		end else if (phase_q == PH_MODIFY && kind_q == KIND_READ) begin
			oerr_q <= 1'b0;
			ona_q  <= (st_rd == ST_NA);
			oval_q <= (st_rd == ST_NA) ? NA_REAL_BITS : cur;
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.result_value = oval_q;
	assign out_ch.result_is_na = ona_q;
	assign out_ch.slot_error = oerr_q;
endmodule

>>> hw/rtl/gmma_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module gmma_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/gmma_addr.sv
// Slot address computation and range check, one register stage.
module gmma_addr import gmma_pkg::*; #(
	parameter int SLOT_DEPTH = 4096
) (
	input  logic                          clk,
	input  logic                          en,
	input  cfg_t                          cfg,
	input  logic [11:0]                   group,
	input  logic [11:0]                   row,
	output logic [$clog2(SLOT_DEPTH)-1:0] slot_s1,
	output logic                          bad_s1
);
	localparam int SW = $clog2(SLOT_DEPTH);

	logic [24:0] prod;
	logic [25:0] slot_full;
	logic        bad;

	// group * rows + row in axis mode, else group; then bounds
	always_comb begin
		prod = 25'(group) * 25'(cfg.row_count);
		slot_full = cfg.axis_mode ? (26'(prod) + 26'(row)) : 26'(group);
		bad = (13'(group) >= cfg.group_count) ||
			(cfg.axis_mode && (13'(row) >= cfg.row_count)) ||
			(slot_full >= 26'(SLOT_DEPTH));
	end

	// held for the whole item once loaded
	always_ff @(posedge clk) begin
		if (en) begin
			slot_s1 <= slot_full[SW-1:0];
			bad_s1  <= bad;
		end
	end
endmodule
